[hw/rtl/mi_pkg.sv]
// ----------------------------------------------------------------------------
// mi_pkg: shared definitions for the modular inverse block
// Operand width, counter width and the operand type.
// ----------------------------------------------------------------------------
`default_nettype none

package mi_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;

endpackage : mi_pkg

`default_nettype wire

[hw/rtl/modular_inverse.sv]
// ----------------------------------------------------------------------------
// modular_inverse: modular inverse by the extended Euclidean algorithm
// Returns value^-1 mod modulus with an existence flag, one result per beat.
// ----------------------------------------------------------------------------
// Usage: write the modulus through cfg_we/cfg_wdata while the block is idle
// (reset value 2). Each input beat on in_value produces exactly one result
// beat with out_inverse in 0..modulus-1 and out_has_inverse set, or both zero
// when value is zero, not below the modulus, or shares a factor with it.
// One item is in flight at a time. Each Euclid step runs as a shift-and-
// subtract long division: the divisor and its Bezout coefficient are shifted
// left one bit per cycle until aligned under the dividend, then shifted back
// right one bit per cycle while one quotient bit is resolved per cycle. All
// Euclid steps share a single subtract and accumulate datapath. Rejected
// values skip the division and go straight to the result. A new beat is
// accepted while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse (
  input  wire            clk,
  input  wire            rst_n,
  // configuration
  input  wire            cfg_we,
  input  mi_pkg::data_t  cfg_wdata,
  // input channel
  input  wire            in_valid,
  output logic           in_ready,
  input  mi_pkg::data_t  in_value,
  // result channel
  output logic           out_valid,
  input  wire            out_ready,
  output mi_pkg::data_t  out_inverse,
  output logic           out_has_inverse
);
  import mi_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_ALIGN = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  // control
  logic [2:0] state_r, state_nxt;
  logic       odd_r, odd_nxt;          // parity of completed Euclid steps
  cnt_t       j_r, j_nxt;              // current quotient bit position
  logic       out_valid_r, out_valid_nxt;
  data_t      modulus_r, modulus_nxt;

  // datapath
  data_t      m_r, m_nxt;              // modulus latched for this item
  data_t      r0_r, r0_nxt, r1_r, r1_nxt;
  data_t      s0_r, s0_nxt, s1_r, s1_nxt;
  data_t      d_r, d_nxt;              // shifted divisor r1 << j
  data_t      t_r, t_nxt;              // shifted coefficient s1 << j
  data_t      out_inverse_r, out_inverse_nxt;
  logic       out_has_r, out_has_nxt;

  logic       in_beat;
  logic       out_free;
  logic       reject;
  logic       can_grow;
  logic       sub_ok;
  data_t      r0_sub, s0_add;
  data_t      s0_red, inv_val;
  logic       ok;

  assign in_ready        = (state_r == ST_IDLE);
  assign in_beat         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_inverse     = out_inverse_r;
  assign out_has_inverse = out_has_r;
  assign out_free        = !out_valid_r || out_ready;

  // refuse values with no possible inverse before any iteration
  assign reject   = (modulus_r < data_t'(2)) || (in_value == '0) || (in_value >= modulus_r);

  // the divisor may still double without passing the dividend
  assign can_grow = !d_r[DATA_WIDTH-1] && ({d_r, 1'b0} <= {1'b0, r0_r});

  // one quotient bit: subtract the aligned divisor, accumulate the coefficient
  assign sub_ok = (r0_r >= d_r);
  assign r0_sub = r0_r - d_r;
  assign s0_add = s0_r + t_r;

  // reduce the final coefficient and fix its sign
  assign ok      = (r0_r == data_t'(1));
  assign s0_red  = (s0_r == m_r) ? '0 : s0_r;
  assign inv_val = (odd_r || (s0_red == '0)) ? s0_red : (m_r - s0_red);

  always_comb begin
    state_nxt       = state_r;
    odd_nxt         = odd_r;
    j_nxt           = j_r;
    out_valid_nxt   = out_valid_r;
    modulus_nxt     = modulus_r;
    m_nxt           = m_r;
    r0_nxt          = r0_r;
    r1_nxt          = r1_r;
    s0_nxt          = s0_r;
    s1_nxt          = s1_r;
    d_nxt           = d_r;
    t_nxt           = t_r;
    out_inverse_nxt = out_inverse_r;
    out_has_nxt     = out_has_r;

    if (cfg_we) begin
      modulus_nxt = cfg_wdata;
    end

    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          m_nxt   = modulus_r;
          r0_nxt  = reject ? '0 : modulus_r;
          r1_nxt  = in_value;
          s0_nxt  = '0;
          s1_nxt  = data_t'(1);
          odd_nxt = 1'b0;
          state_nxt = reject ? ST_FIN : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (r1_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          d_nxt     = r1_r;
          t_nxt     = s1_r;
          j_nxt     = '0;
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (can_grow) begin
          d_nxt = {d_r[DATA_WIDTH-2:0], 1'b0};
          t_nxt = {t_r[DATA_WIDTH-2:0], 1'b0};
          j_nxt = j_r + cnt_t'(1);
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (j_r == '0) begin
          // quotient complete: rotate remainders and coefficients
          r0_nxt    = r1_r;
          r1_nxt    = sub_ok ? r0_sub : r0_r;
          s0_nxt    = s1_r;
          s1_nxt    = sub_ok ? s0_add : s0_r;
          odd_nxt   = !odd_r;
          state_nxt = ST_CHECK;
        end else begin
          if (sub_ok) begin
            r0_nxt = r0_sub;
            s0_nxt = s0_add;
          end
          d_nxt = {1'b0, d_r[DATA_WIDTH-1:1]};
          t_nxt = {1'b0, t_r[DATA_WIDTH-1:1]};
          j_nxt = j_r - cnt_t'(1);
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_has_nxt     = ok;
          out_inverse_nxt = ok ? inv_val : '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      odd_r       <= 1'b0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      modulus_r   <= data_t'(2);
    end else begin
      state_r     <= state_nxt;
      odd_r       <= odd_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      modulus_r   <= modulus_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r           <= m_nxt;
    r0_r          <= r0_nxt;
    r1_r          <= r1_nxt;
    s0_r          <= s0_nxt;
    s1_r          <= s1_nxt;
    d_r           <= d_nxt;
    t_r           <= t_nxt;
    out_inverse_r <= out_inverse_nxt;
    out_has_r     <= out_has_nxt;
  end

`ifndef ASSERT_OFF
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_inverse) |-> (out_inverse == '0))
    else $error("refused result carries a nonzero inverse");

  a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_inverse) |-> (out_inverse < m_r))
    else $error("inverse not below modulus");

  a_rem_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (r0_r > r1_r))
    else $error("remainder sequence not decreasing");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ALIGN) || (state_r == ST_DIV)) |-> (d_r != '0))
    else $error("zero divisor in long division");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while busy");
`endif

endmodule : modular_inverse

`default_nettype wire
